/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL. Every check is sampled on the rising
// clock edge and is switched off while the asynchronous reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/mswdt_pkg.sv */
package mswdt_pkg;

    // Geometry of the watchdog.
    localparam int STAGE_COUNT = 2;
    localparam int COUNT_BITS  = 54;

    // Register map, word indexes.
    localparam int REG_COUNT = STAGE_COUNT * 4 + 4;
    localparam int IX_CONFIG = STAGE_COUNT * 4;
    localparam int IX_STATUS = IX_CONFIG + 1;
    localparam int IX_ARM    = IX_CONFIG + 2;
    localparam int IX_FIRE   = IX_CONFIG + 3;

    // Command codes.
    localparam logic [31:0] ARM_BASE     = 32'h0000_CD00;
    localparam logic [31:0] ARM_DISABLE  = 32'h0000_CD07;
    localparam logic [31:0] FIRE_DISABLE = 32'h0000_07CD;
    localparam logic [7:0]  FIRE_LOW     = 8'hCD;
    localparam logic [23:0] FIRE_SEL_MIN = 24'd1;
    localparam logic [23:0] FIRE_SEL_MAX = 24'd6;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        OP_CAPTURE = 2'd0,
        OP_LOAD    = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_DISABLE = 2'd3
    } op_t;

    // Word within a stage's group of four registers.
    typedef enum logic [1:0] {
        W_TERM_LO = 2'd0,
        W_TERM_HI = 2'd1,
        W_CNT_LO  = 2'd2,
        W_CNT_HI  = 2'd3
    } word_t;

    // One bus or tick transaction.
    typedef struct packed {
        action_t     action;
        logic [3:0]  address;
        logic [31:0] write_data;
    } req_t;

    // Result of one transaction.
    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  timeout_lines;
        logic        final_timeout;
        logic        access_error;
    } rsp_t;

    // Decoded fire command.
    typedef struct packed {
        logic error;
        logic act;
        op_t  op;
        logic stage;
    } fire_t;

    // Reads one 32-bit half of a counter-width value; missing bits read 0.
    function automatic logic [31:0] read_half(logic [COUNT_BITS-1:0] v, logic hi);
        logic [63:0] w;
        w = 64'(v);
        return hi ? w[63:32] : w[31:0];
    endfunction

    // Replaces one 32-bit half of a counter-width value.
    function automatic logic [COUNT_BITS-1:0] write_half(logic [COUNT_BITS-1:0] v,
                                                          logic hi, logic [31:0] d);
        logic [63:0] w;
        w = 64'(v);
        if (hi)
        begin
            w[63:32] = d;
        end
        else
        begin
            w[31:0] = d;
        end
        return w[COUNT_BITS-1:0];
    endfunction

    // Checks a fire code against the armed code.
    function automatic fire_t fire_decode(logic [31:0] fire, logic [31:0] arm);
        fire_t       f;
        logic [23:0] nn;
        logic [23:0] sel;
        f   = '{error: 1'b0, act: 1'b0, op: OP_CAPTURE, stage: 1'b0};
        nn  = fire[31:8];
        sel = nn - FIRE_SEL_MIN;
        if (fire == FIRE_DISABLE)
        begin
            f.op    = OP_DISABLE;
            f.error = (arm != ARM_DISABLE);
            f.act   = (arm == ARM_DISABLE);
        end
        else if (fire[7:0] != FIRE_LOW || nn < FIRE_SEL_MIN || nn > FIRE_SEL_MAX)
        begin
            f.error = 1'b1;
        end
        else if (32'(sel[0]) >= 32'(STAGE_COUNT))
        begin
            f.error = 1'b1;
        end
        else if (arm != (ARM_BASE | {24'h0, nn[7:0]}))
        begin
            f.error = 1'b1;
        end
        else
        begin
            f.act   = 1'b1;
            f.op    = op_t'(sel[2:1]);
            f.stage = sel[0];
        end
        return f;
    endfunction

endpackage

/* sv/mswdt_core.sv */
`include "assert_macros.svh"

module mswdt_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                req_valid,
    input  mswdt_pkg::req_t     req,
    output mswdt_pkg::rsp_t     rsp
);

    localparam int S  = mswdt_pkg::STAGE_COUNT;
    localparam int CB = mswdt_pkg::COUNT_BITS;

    localparam logic [4:0] REG_COUNT_A = 5'(mswdt_pkg::REG_COUNT);
    localparam logic [4:0] IX_CONFIG_A = 5'(mswdt_pkg::IX_CONFIG);
    localparam logic [4:0] IX_STATUS_A = 5'(mswdt_pkg::IX_STATUS);
    localparam logic [4:0] IX_ARM_A    = 5'(mswdt_pkg::IX_ARM);

    // Architectural state.
    logic                 rol_reg;
    logic [S-1:0][CB-1:0] staged_reg,    staged_next;
    logic [S-1:0][CB-1:0] captured_reg,  captured_next;
    logic [S-1:0][CB-1:0] active_reg,    active_next;
    logic [S-1:0][CB-1:0] remaining_reg, remaining_next;
    logic [S-1:0]         running_reg,   running_next;
    logic [S-1:0]         timeout_reg,   timeout_next;
    logic                 en_reg,        en_next;
    logic [7:0]           tickdiv_reg,   tickdiv_next;
    logic                 dbgdis_reg,    dbgdis_next;
    logic [31:0]          arm_reg,       arm_next;
    logic [31:0]          fire_reg,      fire_next;
    logic [7:0]           prescale_reg,  prescale_next;

    logic [S-1:0][CB-1:0] elapsed;
    logic [S-1:0]         expire;
    logic [4:0]           addr_ext;
    logic                 addr_ok;
    logic [31:0]          rd;
    logic                 err;
    logic                 pulse;
    logic [3:0]           st_ext;
    logic                 idle_tick;
    mswdt_pkg::fire_t     fire_dec;

    assign addr_ext = {1'b0, req.address};
    assign addr_ok  = addr_ext < REG_COUNT_A;
    assign fire_dec = mswdt_pkg::fire_decode(req.write_data, arm_reg);

    // Elapsed count and expiry condition per stage.
    always_comb
    begin
        for (int s = 0; s < S; s++)
        begin
            elapsed[s] = active_reg[s] - remaining_reg[s];
            expire[s]  = en_reg && running_reg[s] && (remaining_reg[s] <= CB'(1));
        end
    end

    // Register read path.
    always_comb
    begin
        rd = '0;
        if (addr_ext < IX_CONFIG_A)
        begin
            for (int s = 0; s < S; s++)
            begin
                if (int'(req.address[3:2]) == s)
                begin
                    case (mswdt_pkg::word_t'(req.address[1:0]))
                        mswdt_pkg::W_TERM_LO: rd = mswdt_pkg::read_half(staged_reg[s], 1'b0);
                        mswdt_pkg::W_TERM_HI: rd = mswdt_pkg::read_half(staged_reg[s], 1'b1);
                        mswdt_pkg::W_CNT_LO:  rd = mswdt_pkg::read_half(captured_reg[s], 1'b0);
                        mswdt_pkg::W_CNT_HI:  rd = mswdt_pkg::read_half(captured_reg[s], 1'b1);
                        default:              rd = '0;
                    endcase
                end
            end
        end
        else if (addr_ext == IX_CONFIG_A)
        begin
            rd = 32'({tickdiv_reg, 1'b0, en_reg});
        end
        else if (addr_ext == IX_STATUS_A)
        begin
            rd     = 32'(timeout_reg);
            rd[31] = dbgdis_reg;
        end
        else if (addr_ext == IX_ARM_A)
        begin
            rd = arm_reg;
        end
        else
        begin
            rd = fire_reg;
        end
    end

    // Next state for one transaction.
    always_comb
    begin
        staged_next    = staged_reg;
        captured_next  = captured_reg;
        active_next    = active_reg;
        remaining_next = remaining_reg;
        running_next   = running_reg;
        timeout_next   = timeout_reg;
        en_next        = en_reg;
        tickdiv_next   = tickdiv_reg;
        dbgdis_next    = dbgdis_reg;
        arm_next       = arm_reg;
        fire_next      = fire_reg;
        prescale_next  = prescale_reg;
        err            = 1'b0;
        pulse          = 1'b0;

        if (req_valid)
        begin
            case (req.action)
                mswdt_pkg::ACT_TICK:
                begin
                    if (prescale_reg >= tickdiv_reg)
                    begin
                        prescale_next = '0;
                        if (expire[S-1])
                        begin
                            // Final stage ran out: stop, and reset if configured.
                            pulse                = 1'b1;
                            en_next              = 1'b0;
                            running_next         = '0;
                            remaining_next[S-1]  = '0;
                            timeout_next[S-1]    = 1'b1;
                            if (rol_reg)
                            begin
                                staged_next    = {S{{CB{1'b1}}}};
                                captured_next  = '0;
                                active_next    = {S{{CB{1'b1}}}};
                                remaining_next = {S{{CB{1'b1}}}};
                                timeout_next   = '0;
                                tickdiv_next   = '0;
                                dbgdis_next    = 1'b0;
                                arm_next       = '0;
                                fire_next      = '0;
                            end
                        end
                        else if (en_reg)
                        begin
                            for (int s = 0; s < S; s++)
                            begin
                                if (expire[s])
                                begin
                                    remaining_next[s] = '0;
                                    running_next[s]   = 1'b0;
                                    timeout_next[s]   = 1'b1;
                                end
                                else if (running_reg[s])
                                begin
                                    remaining_next[s] = remaining_reg[s] - CB'(1);
                                end
                            end
                            // An expiry hands over to the next stage, which
                            // starts counting on the following tick.
                            for (int s = 0; s < S - 1; s++)
                            begin
                                if (expire[s])
                                begin
                                    remaining_next[s+1] = active_reg[s+1];
                                    running_next[s+1]   = 1'b1;
                                end
                            end
                        end
                    end
                    else
                    begin
                        prescale_next = prescale_reg + 8'd1;
                    end
                end

                mswdt_pkg::ACT_READ:
                begin
                    err = !addr_ok;
                end

                mswdt_pkg::ACT_WRITE:
                begin
                    if (!addr_ok)
                    begin
                        err = 1'b1;
                    end
                    else if (addr_ext < IX_CONFIG_A)
                    begin
                        for (int s = 0; s < S; s++)
                        begin
                            if (int'(req.address[3:2]) == s)
                            begin
                                if (req.address[1])
                                begin
                                    captured_next[s] = mswdt_pkg::write_half(
                                        captured_reg[s], req.address[0], req.write_data);
                                end
                                else
                                begin
                                    staged_next[s] = mswdt_pkg::write_half(
                                        staged_reg[s], req.address[0], req.write_data);
                                end
                            end
                        end
                    end
                    else if (addr_ext == IX_CONFIG_A)
                    begin
                        // The enable bit can be set here but never cleared.
                        tickdiv_next = req.write_data[9:2];
                        if (req.write_data[0] && !en_reg)
                        begin
                            en_next         = 1'b1;
                            running_next[0] = 1'b1;
                        end
                    end
                    else if (addr_ext == IX_STATUS_A)
                    begin
                        timeout_next = '0;
                        dbgdis_next  = req.write_data[31];
                    end
                    else if (addr_ext == IX_ARM_A)
                    begin
                        arm_next = req.write_data;
                    end
                    else
                    begin
                        fire_next = req.write_data;
                        err       = fire_dec.error;
                        if (fire_dec.act)
                        begin
                            if (fire_dec.op == mswdt_pkg::OP_DISABLE)
                            begin
                                en_next      = 1'b0;
                                running_next = '0;
                            end
                            else
                            begin
                                for (int s = 0; s < S; s++)
                                begin
                                    if (int'(fire_dec.stage) == s)
                                    begin
                                        case (fire_dec.op)
                                            mswdt_pkg::OP_CAPTURE:
                                            begin
                                                captured_next[s] = elapsed[s];
                                            end
                                            mswdt_pkg::OP_LOAD:
                                            begin
                                                // New terminal keeps the elapsed count.
                                                remaining_next[s] =
                                                    (staged_reg[s] >= elapsed[s]) ?
                                                    staged_reg[s] - elapsed[s] : '0;
                                                active_next[s] = staged_reg[s];
                                                if (en_reg)
                                                begin
                                                    running_next[s] = 1'b1;
                                                end
                                            end
                                            mswdt_pkg::OP_CLEAR:
                                            begin
                                                if (en_reg)
                                                begin
                                                    for (int t = 0; t < S; t++)
                                                    begin
                                                        if (t > s)
                                                        begin
                                                            running_next[t] = 1'b0;
                                                        end
                                                    end
                                                    running_next[s] = 1'b1;
                                                end
                                                remaining_next[s] = active_reg[s];
                                                timeout_next[s]   = 1'b0;
                                            end
                                            default:
                                            begin
                                                running_next[s] = running_reg[s];
                                            end
                                        endcase
                                    end
                                end
                            end
                        end
                    end
                end

                default:
                begin
                    err = 1'b0;
                end
            endcase
        end
    end

    // Result of the transaction in flight.
    assign st_ext            = 4'(timeout_next);
    assign rsp.read_data     = (req.action == mswdt_pkg::ACT_READ && addr_ok) ? rd : '0;
    assign rsp.timeout_lines = st_ext[1:0];
    assign rsp.final_timeout = timeout_next[S-1] | pulse;
    assign rsp.access_error  = err;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rol_reg       <= 1'b1;
            staged_reg    <= {S{{CB{1'b1}}}};
            captured_reg  <= '0;
            active_reg    <= {S{{CB{1'b1}}}};
            remaining_reg <= {S{{CB{1'b1}}}};
            running_reg   <= '0;
            timeout_reg   <= '0;
            en_reg        <= 1'b0;
            tickdiv_reg   <= '0;
            dbgdis_reg    <= 1'b0;
            arm_reg       <= '0;
            fire_reg      <= '0;
            prescale_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                rol_reg <= cfg_wdata;
            end
            staged_reg    <= staged_next;
            captured_reg  <= captured_next;
            active_reg    <= active_next;
            remaining_reg <= remaining_next;
            running_reg   <= running_next;
            timeout_reg   <= timeout_next;
            en_reg        <= en_next;
            tickdiv_reg   <= tickdiv_next;
            dbgdis_reg    <= dbgdis_next;
            arm_reg       <= arm_next;
            fire_reg      <= fire_next;
            prescale_reg  <= prescale_next;
        end
    end

    // A tick transaction taken while the watchdog is disabled.
    assign idle_tick = req_valid && !en_reg && (req.action == mswdt_pkg::ACT_TICK);

    // A stage only runs while the watchdog is enabled.
    `ASSERT_IMPL(a_run_needs_en, !en_reg, running_reg == '0)

    // A tick while disabled never moves a counter.
    `ASSERT_NEXT(a_idle_tick_holds, idle_tick, $stable(remaining_reg))

    // The remaining count never exceeds the active terminal.
    for (genvar g = 0; g < S; g++)
    begin : g_chk
        `ASSERT_IMPL(a_rem_le_term, 1'b1, remaining_reg[g] <= active_reg[g])
    end

endmodule

/* sv/multistage_watchdog_timer_top.sv */
// Two-stage watchdog timer behind a bank of twelve 32-bit registers.
//
// Transactions enter on start with action, address and write_data: a base
// clock tick, a bus read or a bus write. busy is always low, so a transaction
// is taken on every clock edge at which start is high. Each transaction gives
// exactly one result on read_data, timeout_lines, final_timeout and
// access_error, marked by done for a single cycle, in the order taken.
// The receiver cannot stall: done is not held and no result is retained.
//
// A transaction is held in the input register and then in the result register, and
// the throughput is one transaction per cycle. The input register feeds one pass
// of logic (a 54-bit decrement and compare per stage, or a load subtraction) that
// updates the state and fills the result register.
//
// cfg_we/cfg_wdata write the expiry-reset bit (reset value 1); write it only
// while no transaction is in flight. Reset (rst_n low) stops all stages,
// disables the watchdog, sets terminals and remaining counts to all ones, clears the rest.
module multistage_watchdog_timer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [3:0]  address,
    input  logic [31:0] write_data,
    output logic        done,
    output logic [31:0] read_data,
    output logic [1:0]  timeout_lines,
    output logic        final_timeout,
    output logic        access_error,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    logic              req_valid_reg;
    mswdt_pkg::req_t   req_reg;
    logic              done_reg;
    mswdt_pkg::rsp_t   rsp_reg;
    mswdt_pkg::rsp_t   rsp_next;

    // A new transaction is taken every cycle.
    assign busy = 1'b0;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= '{action: mswdt_pkg::action_t'(action), address: address,
                     write_data: write_data};
    end

    mswdt_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid_reg),
        .req       (req_reg),
        .rsp       (rsp_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done          = done_reg;
    assign read_data     = rsp_reg.read_data;
    assign timeout_lines = rsp_reg.timeout_lines;
    assign final_timeout = rsp_reg.final_timeout;
    assign access_error  = rsp_reg.access_error;

endmodule

/* tb/tb.sv */
module tb;

    import mswdt_pkg::*;

    // Register fields and masks of the watchdog.
    localparam logic [63:0] CNT_MASK  = (64'd1 << COUNT_BITS) - 64'd1;
    localparam logic [31:0] LO_MASK   = CNT_MASK[31:0];
    localparam logic [31:0] HI_MASK   = CNT_MASK[63:32];
    localparam logic [31:0] CFG_WMASK = 32'h0000_03FD;
    localparam logic [31:0] DBGDIS    = 32'h8000_0000;
    localparam int          STALL_LIMIT = 2000;
    localparam int          DIR_ROWS    = 26;

    // One row of the directed stimulus, with an optional hand-written result.
    typedef struct packed {
        action_t     act;
        logic [3:0]  addr;
        logic [31:0] data;
        logic        typed;
        rsp_t        rsp;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    action_t     action;
    logic [3:0]  address;
    logic [31:0] write_data;
    logic        done;
    logic [31:0] read_data;
    logic [1:0]  timeout_lines;
    logic        final_timeout;
    logic        access_error;
    logic        cfg_we;
    logic        cfg_wdata;

    // Hand-written expectation travelling with the current transaction.
    logic        typed_row;
    rsp_t        typed_rsp;

    // Watchdog model state.
    logic [31:0]           wd_regs [REG_COUNT];
    logic [COUNT_BITS-1:0] term_active [STAGE_COUNT];
    logic [COUNT_BITS-1:0] count_left [STAGE_COUNT];
    bit                    stage_on [STAGE_COUNT];
    bit                    wd_enabled;
    int                    presc_cnt;
    bit                    reset_on_expiry;

    rsp_t     pending_results [$];
    int       fail_count;
    int       items_sent;
    int       gap_pct;
    bit       quiet;
    int       stall_cycles;
    dir_row_t dir_rows [DIR_ROWS];

    multistage_watchdog_timer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .address       (address),
        .write_data    (write_data),
        .done          (done),
        .read_data     (read_data),
        .timeout_lines (timeout_lines),
        .final_timeout (final_timeout),
        .access_error  (access_error),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Terminal currently staged in the register pair of a stage.
    function automatic logic [COUNT_BITS-1:0] staged_term(int s);
        logic [63:0] w;
        w = {wd_regs[4 * s + W_TERM_HI], wd_regs[4 * s + W_TERM_LO]};
        return w[COUNT_BITS-1:0];
    endfunction

    function automatic void stop_watchdog();
        wd_enabled = 1'b0;
        wd_regs[IX_CONFIG][0] = 1'b0;
        for (int s = 0; s < STAGE_COUNT; s++)
            stage_on[s] = 1'b0;
    endfunction

    // Everything returns to its reset value except the expiry reset choice.
    function automatic void clear_state();
        for (int r = 0; r < REG_COUNT; r++)
            wd_regs[r] = '0;
        for (int s = 0; s < STAGE_COUNT; s++)
        begin
            wd_regs[4 * s + W_TERM_LO] = LO_MASK;
            wd_regs[4 * s + W_TERM_HI] = HI_MASK;
            term_active[s] = staged_term(s);
            count_left[s]  = term_active[s];
            stage_on[s]    = 1'b0;
        end
        wd_enabled = 1'b0;
        presc_cnt  = 0;
    endfunction

    // One divided tick: stages are visited from the last to the first, so a
    // stage started by an expiry does not count in the same tick.
    function automatic bit count_tick();
        bit expired_last;
        expired_last = 1'b0;
        for (int s = STAGE_COUNT - 1; s >= 0; s--)
        begin
            if (wd_enabled && stage_on[s])
            begin
                if (count_left[s] > 1)
                    count_left[s] = count_left[s] - 1'b1;
                else
                begin
                    count_left[s] = '0;
                    stage_on[s] = 1'b0;
                    wd_regs[IX_STATUS][s] = 1'b1;
                    if (s + 1 < STAGE_COUNT)
                    begin
                        count_left[s + 1] = term_active[s + 1];
                        stage_on[s + 1] = 1'b1;
                    end
                    else
                    begin
                        stop_watchdog();
                        if (reset_on_expiry)
                            clear_state();
                        expired_last = 1'b1;
                    end
                end
            end
        end
        return expired_last;
    endfunction

    function automatic void run_stage_op(op_t op, int s);
        logic [COUNT_BITS-1:0] elapsed;
        logic [COUNT_BITS-1:0] nt;
        elapsed = term_active[s] - count_left[s];
        if (op == OP_CAPTURE)
        begin
            wd_regs[4 * s + W_CNT_LO] = elapsed[31:0];
            wd_regs[4 * s + W_CNT_HI] = 32'(elapsed[COUNT_BITS-1:32]);
        end
        else if (op == OP_LOAD)
        begin
            // The elapsed count carries over into the new terminal.
            nt = staged_term(s);
            count_left[s]  = (nt >= elapsed) ? nt - elapsed : '0;
            term_active[s] = nt;
            if (wd_enabled)
                stage_on[s] = 1'b1;
        end
        else
        begin
            if (wd_enabled)
            begin
                for (int t = s + 1; t < STAGE_COUNT; t++)
                    stage_on[t] = 1'b0;
                stage_on[s] = 1'b1;
            end
            count_left[s] = term_active[s];
            wd_regs[IX_STATUS][s] = 1'b0;
        end
    endfunction

    // Returns one when the fire code is unknown or does not match the arm code.
    function automatic bit fire_command(logic [31:0] code);
        logic [31:0] armed;
        logic [23:0] nn;
        int          sel;
        armed = wd_regs[IX_ARM];
        nn    = code[31:8];
        if (code == FIRE_DISABLE)
        begin
            if (armed != ARM_DISABLE)
                return 1'b1;
            stop_watchdog();
            return 1'b0;
        end
        if (code[7:0] != FIRE_LOW || nn < 24'd1 || nn > 24'd6)
            return 1'b1;
        sel = int'(nn) - 1;
        if (sel % 2 >= STAGE_COUNT)
            return 1'b1;
        if (armed != (ARM_BASE | 32'(nn)))
            return 1'b1;
        run_stage_op(op_t'(sel / 2), sel % 2);
        return 1'b0;
    endfunction

    function automatic bit register_write(int a, logic [31:0] d);
        logic [31:0] nv;
        if (a < IX_CONFIG)
            wd_regs[a] = d & ((a % 2 == 1) ? HI_MASK : LO_MASK);
        else if (a == IX_CONFIG)
        begin
            // The enable bit is sticky and starts the first stage when set.
            nv = d & CFG_WMASK;
            if (wd_regs[IX_CONFIG][0])
                nv[0] = 1'b1;
            wd_regs[IX_CONFIG] = nv;
            if (nv[0] && !wd_enabled)
            begin
                wd_enabled = 1'b1;
                stage_on[0] = 1'b1;
            end
        end
        else if (a == IX_STATUS)
            wd_regs[IX_STATUS] = d & DBGDIS;
        else if (a == IX_ARM)
            wd_regs[IX_ARM] = d;
        else
        begin
            wd_regs[IX_FIRE] = d;
            return fire_command(d);
        end
        return 1'b0;
    endfunction

    // Applies one transaction to the model and returns its result.
    function automatic rsp_t watchdog_result(action_t a, logic [3:0] ad, logic [31:0] d);
        rsp_t        r;
        logic [7:0]  div;
        bit          expired;
        logic [31:0] st;
        r = '0;
        expired = 1'b0;
        case (a)
            ACT_TICK:
            begin
                div = wd_regs[IX_CONFIG][9:2];
                if (presc_cnt >= int'(div))
                begin
                    presc_cnt = 0;
                    expired = count_tick();
                end
                else
                    presc_cnt++;
            end
            ACT_READ:
            begin
                if (int'(ad) < REG_COUNT)
                    r.read_data = wd_regs[ad];
                else
                    r.access_error = 1'b1;
            end
            ACT_WRITE:
            begin
                if (int'(ad) < REG_COUNT)
                    r.access_error = register_write(int'(ad), d);
                else
                    r.access_error = 1'b1;
            end
            default:
            begin
            end
        endcase
        st = wd_regs[IX_STATUS];
        r.timeout_lines = st[1:0];
        r.final_timeout = st[STAGE_COUNT-1] | expired;
        return r;
    endfunction

    function automatic logic [31:0] arm_word(int nn);
        return ARM_BASE | 32'(nn);
    endfunction

    function automatic logic [31:0] fire_code(int nn);
        return {24'(nn), FIRE_LOW};
    endfunction

    function automatic dir_row_t mk(action_t a, int ad, logic [31:0] d, bit typed,
                                    logic [31:0] rd, bit err);
        dir_row_t row;
        row.act   = a;
        row.addr  = 4'(ad);
        row.data  = d;
        row.typed = typed;
        row.rsp   = {rd, 2'b00, 1'b0, err};
        return row;
    endfunction

    // Terminals are mostly short so that stages expire; a few are huge.
    function automatic logic [COUNT_BITS-1:0] pick_terminal();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r < 16)
            return COUNT_BITS'($urandom_range(1, 12));
        if (r < 19)
            return COUNT_BITS'($urandom_range(13, 300));
        return {22'($urandom), 32'($urandom)};
    endfunction

    // Result checking and the model update on every accepted transaction.
    always @(posedge clk)
    begin : result_check
        rsp_t want;
        rsp_t seen;
        if (rst_n)
        begin
            if (cfg_we)
                reset_on_expiry = cfg_wdata;
            if (start && !busy)
            begin
                want = watchdog_result(action, address, write_data);
                if (typed_row)
                    want = typed_rsp;
                pending_results.push_back(want);
            end
            if (done)
            begin
                seen = {read_data, timeout_lines, final_timeout, access_error};
                if (pending_results.size() == 0)
                begin
                    $error("result without an outstanding transaction");
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (seen.read_data !== want.read_data)
                    begin
                        $error("read_data: expected %h, got %h", want.read_data, seen.read_data);
                        fail_count++;
                    end
                    if (seen.timeout_lines !== want.timeout_lines)
                    begin
                        $error("timeout_lines: expected %b, got %b",
                               want.timeout_lines, seen.timeout_lines);
                        fail_count++;
                    end
                    if (seen.final_timeout !== want.final_timeout)
                    begin
                        $error("final_timeout: expected %b, got %b",
                               want.final_timeout, seen.final_timeout);
                        fail_count++;
                    end
                    if (seen.access_error !== want.access_error)
                    begin
                        $error("access_error: expected %b, got %b",
                               want.access_error, seen.access_error);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Ends the run when nothing has moved for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Drives one transaction, after a random gap, and waits until it is taken.
    task automatic send(action_t a, logic [3:0] ad, logic [31:0] d, bit typed, rsp_t trsp);
        while (!quiet && $urandom_range(0, 99) < gap_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start      <= 1'b1;
        action     <= a;
        address    <= ad;
        write_data <= d;
        typed_row  <= typed;
        typed_rsp  <= trsp;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic put(action_t a, int ad, logic [31:0] d);
        send(a, 4'(ad), d, 1'b0, '0);
    endtask

    task automatic issue_cmd(op_t op, int s);
        int nn;
        if (op == OP_DISABLE)
        begin
            put(ACT_WRITE, IX_ARM, ARM_DISABLE);
            put(ACT_WRITE, IX_FIRE, FIRE_DISABLE);
        end
        else
        begin
            nn = int'(op) * 2 + s + 1;
            put(ACT_WRITE, IX_ARM, arm_word(nn));
            put(ACT_WRITE, IX_FIRE, fire_code(nn));
        end
    endtask

    task automatic write_terminal(int s, logic [COUNT_BITS-1:0] t);
        put(ACT_WRITE, 4 * s + W_TERM_LO, t[31:0]);
        put(ACT_WRITE, 4 * s + W_TERM_HI, {10'($urandom), t[COUNT_BITS-1:32]});
    endtask

    task automatic write_config(bit en);
        int r;
        logic [7:0] div;
        r = $urandom_range(0, 9);
        if (r < 6)
            div = 8'd0;
        else if (r < 9)
            div = 8'($urandom_range(1, 3));
        else
            div = 8'($urandom);
        put(ACT_WRITE, IX_CONFIG, {22'($urandom), div, 1'($urandom), en});
    endtask

    // A countdown: fresh terminals, loads, enable, then mostly ticks mixed
    // with reads, commands and the occasional malformed access.
    task automatic countdown_sequence();
        int r;
        int n;
        int s;
        int nn;
        quiet = ($urandom_range(0, 4) == 0);
        for (s = 0; s < STAGE_COUNT; s++)
        begin
            write_terminal(s, pick_terminal());
            if ($urandom_range(0, 9) < 8)
                issue_cmd(OP_LOAD, s);
        end
        write_config($urandom_range(0, 9) != 0);
        n = $urandom_range(10, 40);
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            s = $urandom_range(0, STAGE_COUNT - 1);
            if (r < 60)
                put(ACT_TICK, $urandom_range(0, 15), $urandom);
            else if (r < 68)
                put(ACT_READ, $urandom_range(0, 15), $urandom);
            else if (r < 74)
                issue_cmd(($urandom_range(0, 1) == 0) ? OP_CAPTURE : OP_CLEAR, s);
            else if (r < 77)
                issue_cmd(OP_LOAD, s);
            else if (r < 80)
                write_terminal(s, pick_terminal());
            else if (r < 83)
                put(ACT_WRITE, IX_STATUS, $urandom);
            else if (r < 85)
                issue_cmd(OP_DISABLE, 0);
            else if (r < 89)
            begin
                // Malformed command: a mismatched arm code or a random fire code.
                nn = $urandom_range(1, 6);
                if ($urandom_range(0, 1) == 0)
                    put(ACT_WRITE, IX_ARM, arm_word((nn % 6) + 1));
                if ($urandom_range(0, 1) == 0)
                    put(ACT_WRITE, IX_FIRE, fire_code(nn));
                else if ($urandom_range(0, 1) == 0)
                    put(ACT_WRITE, IX_FIRE, fire_code($urandom_range(0, 15)));
                else
                    put(ACT_WRITE, IX_FIRE, $urandom);
            end
            else if (r < 92)
                write_config($urandom_range(0, 1));
            else if (r < 95)
                put(ACT_WRITE, 4 * s + W_CNT_LO + $urandom_range(0, 1), $urandom);
            else if (r < 97)
                put(ACT_WRITE, IX_ARM, $urandom);
            else
                put(ACT_NONE, $urandom_range(0, 15), $urandom);
        end
        quiet = 1'b0;
    endtask

    task automatic random_until(int target);
        while (items_sent < target)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    put(action_t'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom);
            end
            else
                countdown_sequence();
        end
    endtask

    // Lets every outstanding transaction come back before the block is touched.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic set_expiry_reset(bit v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        action       = ACT_TICK;
        address      = '0;
        write_data   = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        typed_row    = 1'b0;
        typed_rsp    = '0;
        fail_count   = 0;
        items_sent   = 0;
        gap_pct      = 38;
        quiet        = 1'b0;
        stall_cycles = 0;
        reset_on_expiry = 1'b1;
        clear_state();

        // Reset values, decode errors, malformed commands, then a short countdown
        // in which the first stage expires into the second, with every command kind.
        dir_rows = '{
            mk(ACT_READ,  W_TERM_LO, 32'h0,         1'b1, LO_MASK, 1'b0),
            mk(ACT_READ,  W_TERM_HI, 32'h0,         1'b1, HI_MASK, 1'b0),
            mk(ACT_READ,  12,        32'h0,         1'b1, 32'h0,   1'b1),
            mk(ACT_WRITE, 15,        32'hFFFF_FFFF, 1'b1, 32'h0,   1'b1),
            mk(ACT_NONE,  7,         32'hFFFF_FFFF, 1'b1, 32'h0,   1'b0),
            mk(ACT_WRITE, IX_FIRE,   32'h1234_5678, 1'b1, 32'h0,   1'b1),
            mk(ACT_WRITE, IX_FIRE,   FIRE_DISABLE,  1'b1, 32'h0,   1'b1),
            mk(ACT_WRITE, W_TERM_LO, 32'd3,         1'b0, 32'h0,   1'b0),
            mk(ACT_WRITE, W_TERM_HI, 32'd0,         1'b0, 32'h0,   1'b0),
            mk(ACT_WRITE, 4 + W_TERM_LO, 32'd2,     1'b0, 32'h0,   1'b0),
            mk(ACT_WRITE, 4 + W_TERM_HI, 32'd0,     1'b0, 32'h0,   1'b0),
            mk(ACT_WRITE, IX_ARM,    arm_word(3),   1'b0, 32'h0,   1'b0),
            mk(ACT_WRITE, IX_FIRE,   fire_code(3),  1'b0, 32'h0,   1'b0),
            mk(ACT_WRITE, IX_ARM,    arm_word(4),   1'b0, 32'h0,   1'b0),
            mk(ACT_WRITE, IX_FIRE,   fire_code(4),  1'b0, 32'h0,   1'b0),
            mk(ACT_WRITE, IX_CONFIG, 32'hFFFF_FC01, 1'b0, 32'h0,   1'b0),
            mk(ACT_TICK,  0,         32'h0,         1'b0, 32'h0,   1'b0),
            mk(ACT_TICK,  15,        32'hFFFF_FFFF, 1'b0, 32'h0,   1'b0),
            mk(ACT_TICK,  0,         32'h0,         1'b0, 32'h0,   1'b0),
            mk(ACT_WRITE, IX_ARM,    arm_word(1),   1'b0, 32'h0,   1'b0),
            mk(ACT_WRITE, IX_FIRE,   fire_code(1),  1'b0, 32'h0,   1'b0),
            mk(ACT_WRITE, IX_ARM,    arm_word(5),   1'b0, 32'h0,   1'b0),
            mk(ACT_WRITE, IX_FIRE,   fire_code(5),  1'b0, 32'h0,   1'b0),
            mk(ACT_WRITE, IX_ARM,    ARM_DISABLE,   1'b0, 32'h0,   1'b0),
            mk(ACT_WRITE, IX_FIRE,   FIRE_DISABLE,  1'b0, 32'h0,   1'b0),
            mk(ACT_WRITE, IX_FIRE,   fire_code(5),  1'b0, 32'h0,   1'b0)
        };

        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Random sender gaps (gap_pct of 38), expiry resets the block.
        set_expiry_reset(1'b1);
        for (int i = 0; i < DIR_ROWS; i++)
            send(dir_rows[i].act, dir_rows[i].addr, dir_rows[i].data,
                 dir_rows[i].typed, dir_rows[i].rsp);
        random_until(470);
        drain();

        // Heavier sender gaps, expiry only disables the block.
        set_expiry_reset(1'b0);
        gap_pct = 55;
        random_until(940);
        drain();

        // Back to back, both expiry settings.
        set_expiry_reset(1'b1);
        gap_pct = 0;
        random_until(1170);
        drain();
        set_expiry_reset(1'b0);
        random_until(1400);
        drain();

        repeat (8)
            @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
